// ===== rtl/core/ohash_pkg.sv =====
// shared types and constants for the open-addressing hash table
package ohash_pkg;

    localparam int TABLE_SIZE_DEF = 64;
    localparam int CNT_W          = 7;

    localparam logic [2:0] OP_PUT       = 3'd0;
    localparam logic [2:0] OP_PUT_NEW   = 3'd1;
    localparam logic [2:0] OP_GET       = 3'd2;
    localparam logic [2:0] OP_DEL       = 3'd3;
    localparam logic [2:0] OP_DEL_MATCH = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef logic [CNT_W-1:0] t_count;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] key;
        logic [31:0] key_hash;
        logic [31:0] value;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value_out;
        t_count      live_count;
        t_count      occupied_count;
    } t_result;

    // one table slot as held in the memory
    typedef struct packed {
        logic [31:0] hash;
        logic        tomb;
        logic [31:0] key;
        logic [31:0] value;
    } t_entry;

endpackage

// ===== rtl/core/ohash_ram.sv =====
// generic single-write, single-read ram with registered read data
module ohash_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/ohash_ctrl.sv =====
// probe sequencer: walks the probe path through the slot ram and applies the op
module ohash_ctrl #(
    parameter int TABLE_SIZE = ohash_pkg::TABLE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  ohash_pkg::t_item              i_item,
    output logic                          o_busy,
    output logic                          o_done,
    output ohash_pkg::t_result            o_result,
    output logic                          o_wr_en,
    output logic [$clog2(TABLE_SIZE)-1:0] o_wr_addr,
    output ohash_pkg::t_entry             o_wr_data,
    output logic [$clog2(TABLE_SIZE)-1:0] o_rd_addr,
    input  ohash_pkg::t_entry             i_rd_data
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_MOVE
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_op, n_op;
    logic [31:0]        r_key, n_key;
    logic [31:0]        r_hk, n_hk;
    logic [31:0]        r_val, n_val;
    logic [AW-1:0]      r_start, n_start;
    logic [AW-1:0]      r_inc, n_inc;
    logic [AW-1:0]      r_cur, n_cur;
    logic               r_have, n_have;
    logic [AW-1:0]      r_reuse, n_reuse;
    logic [CW-1:0]      r_live, n_live;
    logic [CW-1:0]      r_occ, n_occ;
    logic [TABLE_SIZE-1:0] r_valid, n_valid;
    logic               r_rd_vld, n_rd_vld;
    logic               r_done, n_done;
    ohash_pkg::t_result r_res, n_res;

    ohash_pkg::t_entry  d;
    logic               adding;
    logic               l_have;
    logic [AW-1:0]      l_reuse;
    logic [AW-1:0]      nxt;
    logic [AW-1:0]      s0;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_hk     = r_hk;
        n_val    = r_val;
        n_start  = r_start;
        n_inc    = r_inc;
        n_cur    = r_cur;
        n_have   = r_have;
        n_reuse  = r_reuse;
        n_live   = r_live;
        n_occ    = r_occ;
        n_valid  = r_valid;
        n_done   = 1'b0;
        n_res    = r_res;
        o_wr_en   = 1'b0;
        o_wr_addr = r_cur;
        o_wr_data = '0;
        o_rd_addr = r_cur;

        // slots never written read as blank
        d       = r_rd_vld ? i_rd_data : '0;
        adding  = (r_op == ohash_pkg::OP_PUT) || (r_op == ohash_pkg::OP_PUT_NEW);
        nxt     = r_cur + r_inc;
        l_have  = r_have;
        l_reuse = r_reuse;
        s0      = i_item.key_hash[AW-1:0];

        case (r_state)
            S_IDLE: begin
                o_rd_addr = s0;
                if (i_start) begin
                    n_op    = i_item.op;
                    n_key   = i_item.key;
                    n_hk    = i_item.key_hash;
                    n_val   = i_item.value;
                    n_start = s0;
                    n_inc   = s0 | AW'(1);
                    n_cur   = s0;
                    n_have  = 1'b0;
                    n_res   = '0;
                    if (i_item.op > ohash_pkg::OP_DEL_MATCH || i_item.key_hash == '0) begin
                        n_res.status = ohash_pkg::ST_INVALID;
                        n_done       = 1'b1;
                    end else begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                n_res.status    = ohash_pkg::ST_OK;
                n_res.value_out = '0;
                if (d.hash == r_hk && d.key == r_key) begin
                    n_res.value_out = d.value;
                    n_state         = S_IDLE;
                    n_done          = 1'b1;
                    if (adding) begin
                        if (r_op == ohash_pkg::OP_PUT_NEW) begin
                            n_res.status = ohash_pkg::ST_EXISTS;
                        end
                        if (r_have) begin
                            // move the entry into the earliest tombstone
                            o_wr_en   = 1'b1;
                            o_wr_addr = r_reuse;
                            o_wr_data = '{hash: r_hk, tomb: 1'b0, key: r_key,
                                value: (r_op == ohash_pkg::OP_PUT) ? r_val : d.value};
                            n_state   = S_MOVE;
                            n_done    = 1'b0;
                        end else if (r_op == ohash_pkg::OP_PUT) begin
                            o_wr_en   = 1'b1;
                            o_wr_data = '{hash: r_hk, tomb: 1'b0, key: r_key, value: r_val};
                        end
                    end else if (r_op == ohash_pkg::OP_DEL_MATCH && d.value != r_val) begin
                        n_res.status = ohash_pkg::ST_MISMATCH;
                    end else if (r_op != ohash_pkg::OP_GET) begin
                        o_wr_en   = 1'b1;
                        o_wr_data = '{hash: '0, tomb: 1'b1, key: d.key, value: d.value};
                        n_live    = r_live - CW'(1);
                    end
                end else if (d.hash == '0 && !d.tomb) begin
                    // blank slot ends the probe
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (adding) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_have ? r_reuse : r_cur;
                        o_wr_data = '{hash: r_hk, tomb: 1'b0, key: r_key, value: r_val};
                        n_live    = r_live + CW'(1);
                        if (!r_have) begin
                            n_occ = r_occ + CW'(1);
                        end
                    end else begin
                        n_res.status = ohash_pkg::ST_NOTFOUND;
                    end
                end else begin
                    if (d.hash == '0 && adding && !r_have) begin
                        l_have  = 1'b1;
                        l_reuse = r_cur;
                    end
                    n_have  = l_have;
                    n_reuse = l_reuse;
                    if (nxt == r_start) begin
                        // full wrap
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                        if (adding && l_have) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = l_reuse;
                            o_wr_data = '{hash: r_hk, tomb: 1'b0, key: r_key, value: r_val};
                            n_live    = r_live + CW'(1);
                        end else if (adding) begin
                            n_res.status = ohash_pkg::ST_FULL;
                        end else begin
                            n_res.status = ohash_pkg::ST_NOTFOUND;
                        end
                    end else begin
                        n_cur     = nxt;
                        o_rd_addr = nxt;
                    end
                end
            end
            S_MOVE: begin
                // old slot of a moved entry becomes a tombstone
                o_wr_en   = 1'b1;
                o_wr_data = '{hash: '0, tomb: 1'b1, key: r_key, value: r_val};
                n_state   = S_IDLE;
                n_done    = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_wr_en) begin
            n_valid[o_wr_addr] = 1'b1;
        end
        n_rd_vld = r_valid[o_rd_addr];
        n_res.live_count     = ohash_pkg::t_count'(n_live);
        n_res.occupied_count = ohash_pkg::t_count'(n_occ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_occ   <= '0;
            r_valid <= '0;
            r_done  <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_occ   <= n_occ;
            r_valid <= n_valid;
            r_done  <= n_done;
            r_have  <= n_have;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_hk     <= n_hk;
        r_val    <= n_val;
        r_start  <= n_start;
        r_inc    <= n_inc;
        r_cur    <= n_cur;
        r_reuse  <= n_reuse;
        r_rd_vld <= n_rd_vld;
        r_res    <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== rtl/core/open_addressing_hash_table.sv =====
// top level of the open-addressing key/value table with tombstones
//
//  channel   ports                          handshake
//  item in   start, busy, i_item            beat taken when start && !busy
//  result    o_done, o_result               one-cycle strobe, cannot be held off
//
// an item walks its probe path one slot at a time, with an extra step when a found key is
// moved into an earlier tombstone; a zero hash or unknown op answers without a walk
// the probe loop is set by the slot ram: one read per cycle, with registered read data
// busy stays high from the beat of a probed item until the result strobe; the next
// beat may come in the strobe cycle
// reset clears per-slot valid bits at once, so no clearing pass is needed
module open_addressing_hash_table #(
    parameter int TABLE_SIZE = ohash_pkg::TABLE_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ohash_pkg::t_item   i_item,
    output logic               o_done,
    output ohash_pkg::t_result o_result
);

    localparam int AW = $clog2(TABLE_SIZE);

    // ram side of the sequencer
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    ohash_pkg::t_entry wr_data;
    logic [AW-1:0]     rd_addr;
    ohash_pkg::t_entry rd_data;

    // slot store: hash, tombstone flag, key and value in one word
    ohash_ram #(
        .WIDTH ($bits(ohash_pkg::t_entry)),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // probe sequencer, counters and valid bits
    ohash_ctrl #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .o_busy    (busy),
        .o_done    (o_done),
        .o_result  (o_result),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    // every finished probe walk ends in a result beat
    a_busy_ends_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_done)
        else $error("busy dropped without a result");

    // an accepted beat either starts a walk or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted beat lost");

    // live entries never exceed occupied slots
    a_counts_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.live_count <= o_result.occupied_count))
        else $error("live count above occupied count");

    // no result beat while a walk is in flight
    a_no_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result strobe during walk");

endmodule

// ===== sim/open_addressing_hash_table_tb.sv =====
// testbench for the open-addressing hash table: directed and random ops checked against a table model
`timescale 1ns / 100ps

class table_scoreboard;
    localparam int SLOTS = 64;
    logic [31:0] m_hash [SLOTS];
    logic        m_tomb [SLOTS];
    logic [31:0] m_key  [SLOTS];
    logic [31:0] m_val  [SLOTS];
    int unsigned m_live;
    int unsigned m_occ;
    ohash_pkg::t_result pending[$];
    int          errors;

    function new();
        for (int i = 0; i < SLOTS; i++) begin
            m_hash[i] = '0;
            m_tomb[i] = 1'b0;
            m_key[i]  = '0;
            m_val[i]  = '0;
        end
        m_live = 0;
        m_occ  = 0;
        errors = 0;
    endfunction

    // walk the probe path; returns 0 found, 1 blank/reuse slot, 2 miss
    function int walk(logic [31:0] hk, logic [31:0] key, bit adding, output int where);
        int st;
        int inc;
        int cur;
        bit have_reuse;
        int reuse;
        st = hk & (SLOTS - 1);
        inc = st[0] ? st : st + 1;
        cur = st;
        have_reuse = 0;
        reuse = 0;
        where = 0;
        for (int n = 0; n < SLOTS; n++) begin
            if (m_hash[cur] == hk && m_key[cur] == key) begin
                if (adding && have_reuse) begin
                    // pull the entry forward into the earliest tombstone
                    m_key[reuse]  = m_key[cur];
                    m_val[reuse]  = m_val[cur];
                    m_hash[reuse] = hk;
                    m_tomb[reuse] = 1'b0;
                    m_hash[cur]   = '0;
                    m_tomb[cur]   = 1'b1;
                    where = reuse;
                end else begin
                    where = cur;
                end
                return 0;
            end
            if (m_hash[cur] == '0) begin
                if (!m_tomb[cur]) begin
                    if (!adding) return 2;
                    where = have_reuse ? reuse : cur;
                    return 1;
                end
                if (adding && !have_reuse) begin
                    have_reuse = 1;
                    reuse = cur;
                end
            end
            cur = (cur + inc) & (SLOTS - 1);
            if (cur == st) break;
        end
        if (adding && have_reuse) begin
            where = reuse;
            return 1;
        end
        return 2;
    endfunction

    function void note_item(ohash_pkg::t_item it);
        ohash_pkg::t_result r;
        int where;
        int pr;
        r.status = ohash_pkg::ST_OK;
        r.value_out = '0;
        if (it.op > ohash_pkg::OP_DEL_MATCH || it.key_hash == '0) begin
            r.status = ohash_pkg::ST_INVALID;
        end else if (it.op == ohash_pkg::OP_PUT || it.op == ohash_pkg::OP_PUT_NEW) begin
            pr = walk(it.key_hash, it.key, 1, where);
            if (pr == 0) begin
                r.value_out = m_val[where];
                if (it.op == ohash_pkg::OP_PUT_NEW) r.status = ohash_pkg::ST_EXISTS;
                else m_val[where] = it.value;
            end else if (pr == 1) begin
                if (!m_tomb[where]) m_occ++;
                m_tomb[where] = 1'b0;
                m_hash[where] = it.key_hash;
                m_key[where]  = it.key;
                m_val[where]  = it.value;
                m_live++;
            end else begin
                r.status = ohash_pkg::ST_FULL;
            end
        end else begin
            pr = walk(it.key_hash, it.key, 0, where);
            if (pr != 0) begin
                r.status = ohash_pkg::ST_NOTFOUND;
            end else begin
                r.value_out = m_val[where];
                if (it.op == ohash_pkg::OP_DEL_MATCH && m_val[where] != it.value) begin
                    r.status = ohash_pkg::ST_MISMATCH;
                end else if (it.op != ohash_pkg::OP_GET) begin
                    m_hash[where] = '0;
                    m_tomb[where] = 1'b1;
                    m_live--;
                end
            end
        end
        r.live_count = ohash_pkg::t_count'(m_live);
        r.occupied_count = ohash_pkg::t_count'(m_occ);
        pending.push_back(r);
    endfunction

    function void check_result(ohash_pkg::t_result got);
        ohash_pkg::t_result exp;
        if (pending.size() == 0) begin
            $display("%0t unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.status !== exp.status)
            $display("%0t status exp %0d got %0d", $time, exp.status, got.status);
        if (got.value_out !== exp.value_out)
            $display("%0t value_out exp %h got %h", $time, exp.value_out, got.value_out);
        if (got.live_count !== exp.live_count)
            $display("%0t live_count exp %0d got %0d", $time, exp.live_count,
                     got.live_count);
        if (got.occupied_count !== exp.occupied_count)
            $display("%0t occupied_count exp %0d got %0d", $time, exp.occupied_count,
                     got.occupied_count);
        if (got !== exp) errors++;
    endfunction
endclass

module open_addressing_hash_table_tb;
    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    ohash_pkg::t_item   i_item;
    logic               o_done;
    ohash_pkg::t_result o_result;

    table_scoreboard sb;
    int unsigned cycles;

    // small pool of keys so that repeats, tombstones and moves are common
    logic [31:0] pool_key  [16];
    logic [31:0] pool_hash [16];

    open_addressing_hash_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result beats cannot be held off: check every strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    // watchdog: ~1420 items plus gaps, with a wide margin
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // present one beat and hold it until taken; start stays high across back-to-back beats
    task automatic send(ohash_pkg::t_item it, bit keep);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        if (!keep) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic gap(int n);
        repeat (n) @(posedge i_clk);
    endtask

    function automatic ohash_pkg::t_item mk(logic [2:0] op, logic [31:0] k, logic [31:0] h,
                                            logic [31:0] v);
        ohash_pkg::t_item it;
        it.op = op;
        it.key = k;
        it.key_hash = h;
        it.value = v;
        return it;
    endfunction

    function automatic ohash_pkg::t_item rand_item();
        int p;
        int sel;
        logic [2:0] op;
        p = $urandom_range(0, 15);
        sel = $urandom_range(0, 99);
        if (sel < 30) op = ohash_pkg::OP_PUT;
        else if (sel < 45) op = ohash_pkg::OP_PUT_NEW;
        else if (sel < 65) op = ohash_pkg::OP_GET;
        else if (sel < 82) op = ohash_pkg::OP_DEL;
        else if (sel < 96) op = ohash_pkg::OP_DEL_MATCH;
        else op = 3'($urandom_range(5, 7));
        if (sel >= 96 && $urandom_range(0, 1)) op = ohash_pkg::OP_GET;
        // noise: fresh keys, colliding keys, zero hash
        if ($urandom_range(0, 19) == 0)
            return mk(op, $urandom, $urandom_range(0, 1) ? 32'h0 : $urandom, $urandom);
        if ($urandom_range(0, 9) == 0)
            return mk(op, $urandom, pool_hash[p], $urandom);
        return mk(op, pool_key[p], pool_hash[p],
                  $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : $urandom);
    endfunction

    initial begin
        ohash_pkg::t_item it;
        int burst;
        cycles = 0;
        sb = new();
        start = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        for (int i = 0; i < 16; i++) begin
            pool_key[i] = $urandom;
            // several share a start slot to force long probes
            pool_hash[i] = {26'($urandom_range(1, 32'h3FFFFFF)), 6'($urandom_range(0, 5))};
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every op, extremes, zero hash, unknown ops, put-if-absent on present key
        send(mk(ohash_pkg::OP_GET, 32'h0, 32'h1, 32'h0), 0);
        send(mk(ohash_pkg::OP_PUT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF), 0);
        send(mk(ohash_pkg::OP_PUT, 32'h0, 32'h40, 32'h0), 1);
        send(mk(ohash_pkg::OP_PUT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h12345678), 1);
        send(mk(ohash_pkg::OP_PUT_NEW, 32'h0, 32'h40, 32'h5), 0);
        send(mk(ohash_pkg::OP_PUT, 32'h1, 32'h0, 32'h1), 0);
        send(mk(3'd5, 32'h1, 32'h1, 32'h1), 0);
        send(mk(3'd7, 32'h1, 32'h1, 32'h1), 0);
        send(mk(ohash_pkg::OP_DEL_MATCH, 32'h0, 32'h40, 32'h9), 0);
        send(mk(ohash_pkg::OP_DEL_MATCH, 32'h0, 32'h40, 32'h0), 0);
        send(mk(ohash_pkg::OP_PUT_NEW, 32'h7, 32'h80, 32'h7), 0);
        send(mk(ohash_pkg::OP_DEL, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0), 0);
        send(mk(ohash_pkg::OP_DEL, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0), 0);
        send(mk(ohash_pkg::OP_GET, 32'h7, 32'h80, 32'h0), 0);
        // fill every slot, then put again for a full wrap, then delete to make tombstones
        for (int i = 0; i < 64; i++)
            send(mk(ohash_pkg::OP_PUT, 32'h1000 + i, 32'(i * 64 + i + 1), 32'(i)), 1);
        send(mk(ohash_pkg::OP_PUT, 32'hDEAD, 32'h3, 32'h1), 1);
        send(mk(ohash_pkg::OP_GET, 32'hBEEF, 32'h5, 32'h1), 0);
        for (int i = 0; i < 64; i += 3)
            send(mk(ohash_pkg::OP_DEL, 32'h1000 + i, 32'(i * 64 + i + 1), 32'h0), 1);
        send(mk(ohash_pkg::OP_PUT, 32'h1002, 32'(2 * 64 + 2 + 1), 32'hA), 0);
        for (int i = 0; i < 64; i++)
            send(mk(ohash_pkg::OP_DEL, 32'h1000 + i, 32'(i * 64 + i + 1), 32'h0), 0);

        // random bursts with random gaps
        for (int n = 0; n < 1250;) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
                it = rand_item();
                send(it, b != burst - 1);
                n++;
            end
            if ($urandom_range(0, 3) != 0) gap($urandom_range(0, 15));
        end

        while (sb.pending.size() != 0) @(posedge i_clk);
        gap(80);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/ohash_pkg.sv
rtl/core/ohash_ram.sv
rtl/core/ohash_ctrl.sv
rtl/core/open_addressing_hash_table.sv
sim/open_addressing_hash_table_tb.sv
